/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the router RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated by active-low reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, gated by active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/frt_pkg.sv */
// ---------------------------------------------------------------------------
// frt_pkg
// Types, codes and sizes shared by the fat-tree credit router modules.
// ---------------------------------------------------------------------------
package frt_pkg;

    // port counts follow the four-byte neighbor maps
    localparam int UPPER_PORTS = 4;
    localparam int LOWER_PORTS = 4;
    localparam int NQ          = UPPER_PORTS + LOWER_PORTS;
    localparam int QW          = $clog2(NQ);
    localparam int PW          = 2;

    localparam int DEF_INPUT_DEPTH   = 4;
    localparam int DEF_CENTRAL_DEPTH = 8;
    localparam int DEF_MAX_CREDITS   = 4;

    localparam logic [7:0] NO_NEIGHBOR = 8'hFF;

    // commands
    localparam logic [2:0] CMD_INJECT     = 3'd0;
    localparam logic [2:0] CMD_RECV_UPPER = 3'd1;
    localparam logic [2:0] CMD_RECV_LOWER = 3'd2;
    localparam logic [2:0] CMD_CRED_UPPER = 3'd3;
    localparam logic [2:0] CMD_CRED_LOWER = 3'd4;
    localparam logic [2:0] CMD_TICK       = 3'd5;

    // register indexes
    localparam logic [1:0] REG_ROUTER_ID = 2'd0;
    localparam logic [1:0] REG_UPPER_MAP = 2'd1;
    localparam logic [1:0] REG_LOWER_MAP = 2'd2;

    // target kinds
    localparam logic [1:0] KIND_LOCAL = 2'd0;
    localparam logic [1:0] KIND_DOWN  = 2'd1;
    localparam logic [1:0] KIND_UP    = 2'd2;

    // central buffers
    localparam int CEN_UP   = 0;
    localparam int CEN_DOWN = 1;

    // serve steps: lower inputs, central up, upper inputs, central down
    localparam int STEP_CUP    = LOWER_PORTS;
    localparam int STEP_UPPER0 = LOWER_PORTS + 1;
    localparam int STEP_CDOWN  = LOWER_PORTS + UPPER_PORTS + 1;
    localparam int STEP_W      = $clog2(STEP_CDOWN + 1);

    typedef logic [31:0] t_pkt;

    typedef struct packed {
        logic       acc;
        logic       fv;
        logic [1:0] kind;
        logic [7:0] trouter;
        logic [1:0] tport;
        t_pkt       pkt;
    } t_row;

    typedef struct packed {
        logic              load;
        logic              exec;
        logic              serve;
        logic              drain;
        logic              flush;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic in_is_tick;
        logic out_free;
        logic drain_busy;
        logic pend_valid;
    } t_dp_stat;

endpackage

/* rtl/core/fat_tree_credit_router_unit.sv */
// ---------------------------------------------------------------------------
// fat_tree_credit_router_unit
// Fat-tree router with credit flow control, staging queues and central
// up/down overflow buffers.
//
//   channel  | dir | tdata                                       | tuser
//   s_axis   | in  | port, pkt_id, dest_router, dest_terminal    | cmd
//   m_axis   | out | accepted, next hop id, out port,            | forward_valid,
//            |     | out_pkt_id, out_dest_router, out_dest_term. | target_kind
//   cfg      | in  | write enable, register index, 32-bit data   | -
//
// A non-tick item runs its command and returns one result row. A tick runs 10
// serve steps (one queue head per cycle through the shared port selector, while
// the output is free), then drains the staging queues into the current queues
// and then closes the run.
// Reset is synchronous, active low; queues empty, credits full.
// A stalled output holds the sequencer; no new item is taken mid-run.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fat_tree_credit_router_unit
    import frt_pkg::*;
#(
    parameter int INPUT_DEPTH   = DEF_INPUT_DEPTH,
    parameter int CENTRAL_DEPTH = DEF_CENTRAL_DEPTH,
    parameter int MAX_CREDITS   = DEF_MAX_CREDITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // port[1:0], pkt_id[17:2], dest_router[25:18], dest_terminal[33:26]
    input  logic [39:0] i_s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // accepted[0], next hop id[8:1], out port[10:9], out_pkt_id[26:11],
    // out_dest_router[34:27], out_dest_terminal[42:35]
    output logic [47:0] o_m_axis_tdata,
    // forward_valid[0], target_kind[2:1]
    output logic [2:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_row     w_row;

    frt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd)
    );

    frt_dp #(
        .INPUT_DEPTH  (INPUT_DEPTH),
        .CENTRAL_DEPTH(CENTRAL_DEPTH),
        .MAX_CREDITS  (MAX_CREDITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (i_s_axis_tuser),
        .i_port     (i_s_axis_tdata[1:0]),
        .i_pkt      ({i_s_axis_tdata[17:2], i_s_axis_tdata[25:18], i_s_axis_tdata[33:26]}),
        .i_m_ready  (i_m_axis_tready),
        .i_ctl      (w_cmd),
        .o_stat     (w_stat),
        .o_valid    (o_m_axis_tvalid),
        .o_row      (w_row),
        .o_last     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'b0, w_row.pkt[7:0], w_row.pkt[15:8], w_row.pkt[31:16],
                             w_row.tport, w_row.trouter, w_row.acc};
    assign o_m_axis_tuser = {w_row.kind, w_row.fv};

    // a held forward means a tick is still running
    `ASSERT_IMPLIES(a_pend_blocks_input, i_clk, i_rst_n,
        w_stat.pend_valid, !o_s_axis_tready)
    // an accepted item closes the input until its run is done
    `ASSERT_NEXT(a_accept_closes_input, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    // forward rows never claim acceptance
    `ASSERT_IMPLIES(a_fwd_not_acc, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser[0], !o_m_axis_tdata[0])

endmodule

/* rtl/core/frt_fifo.sv */
// ---------------------------------------------------------------------------
// frt_fifo
// Small packet queue: circular register store with head pointer and count.
// ---------------------------------------------------------------------------
module frt_fifo
    import frt_pkg::*;
#(
    parameter int DEPTH = DEF_INPUT_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_din,
    input  logic i_pop,
    output t_pkt o_head,
    output logic o_empty,
    output logic o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    t_pkt          r_mem [DEPTH];
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] w_sum, w_wr;
    logic          w_push, w_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_head  = r_mem[r_head];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    assign w_sum = SW'(r_head) + SW'(r_cnt);
    assign w_wr  = (w_sum >= SW'(DEPTH)) ? w_sum - SW'(DEPTH) : w_sum;

    always_comb begin
        n_head = r_head;
        n_cnt  = r_cnt;
        if (w_pop) begin
            n_head = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[w_wr[AW-1:0]] <= i_din;
        end
    end

endmodule

/* rtl/core/frt_ctrl.sv */
// ---------------------------------------------------------------------------
// frt_ctrl
// Sequencer: takes an item, runs the command or the serve steps of a tick,
// drains staging queues and closes the result run.
// ---------------------------------------------------------------------------
module frt_ctrl
    import frt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    output logic     o_s_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMD   = 3'd1;
    localparam logic [2:0] ST_SERVE = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_accept;

    // hold the input closed while reset is asserted
    assign o_s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign o_cmd.load  = w_accept;
    assign o_cmd.exec  = (r_state == ST_CMD) && i_stat.out_free;
    assign o_cmd.serve = (r_state == ST_SERVE) && i_stat.out_free;
    assign o_cmd.drain = (r_state == ST_DRAIN) && i_stat.drain_busy;
    assign o_cmd.flush = (r_state == ST_FLUSH) && i_stat.out_free;
    assign o_cmd.step  = r_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_step  = '0;
                    n_state = i_stat.in_is_tick ? ST_SERVE : ST_CMD;
                end
            end
            ST_CMD: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            ST_SERVE: begin
                if (i_stat.out_free) begin
                    if (r_step == STEP_W'(STEP_CDOWN)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_step = r_step + STEP_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_stat.drain_busy) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

/* rtl/core/frt_dp.sv */
// ---------------------------------------------------------------------------
// frt_dp
// Datapath: configuration, queues, credits, port selection and result rows.
// ---------------------------------------------------------------------------
module frt_dp
    import frt_pkg::*;
#(
    parameter int INPUT_DEPTH   = DEF_INPUT_DEPTH,
    parameter int CENTRAL_DEPTH = DEF_CENTRAL_DEPTH,
    parameter int MAX_CREDITS   = DEF_MAX_CREDITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic [2:0]  i_cmd,
    input  logic [1:0]  i_port,
    input  t_pkt        i_pkt,
    input  logic        i_m_ready,
    input  t_dp_cmd     i_ctl,
    output t_dp_stat    o_stat,
    output logic        o_valid,
    output t_row        o_row,
    output logic        o_last
);

    localparam int CW = $clog2(MAX_CREDITS + 1);

    // configuration and captured item
    logic [7:0]  r_rid;
    logic [31:0] r_umap, r_lmap;
    logic [2:0]  r_in_cmd;
    logic [1:0]  r_in_port;
    t_pkt        r_in_pkt;

    logic [CW-1:0] r_ucred [UPPER_PORTS];
    logic [CW-1:0] r_lcred [LOWER_PORTS];
    logic [PW-1:0] r_up_rr, r_dn_rr;

    t_row r_out, r_pend;
    logic r_out_valid, r_out_last, r_pend_valid;
    logic w_out_free;

    // port queues: lower ports first, then upper ports
    logic [NQ-1:0] w_cur_push, w_cur_pop, w_cur_empty, w_cur_full;
    logic [NQ-1:0] w_stg_push, w_stg_pop, w_stg_empty, w_stg_full;
    t_pkt          w_cur_head [NQ];
    t_pkt          w_stg_head [NQ];
    logic [1:0]    w_cc_push, w_cc_pop, w_cc_empty, w_cc_full;
    logic [1:0]    w_cs_push, w_cs_pop, w_cs_empty, w_cs_full;
    t_pkt          w_cc_head [2];
    t_pkt          w_cs_head [2];

    for (genvar q = 0; q < NQ; q++) begin : g_portq
        frt_fifo #(.DEPTH(INPUT_DEPTH)) u_cur (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_push (w_cur_push[q]),
            .i_din  (w_stg_head[q]),
            .i_pop  (w_cur_pop[q]),
            .o_head (w_cur_head[q]),
            .o_empty(w_cur_empty[q]),
            .o_full (w_cur_full[q])
        );
        frt_fifo #(.DEPTH(INPUT_DEPTH)) u_stg (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_push (w_stg_push[q]),
            .i_din  (r_in_pkt),
            .i_pop  (w_stg_pop[q]),
            .o_head (w_stg_head[q]),
            .o_empty(w_stg_empty[q]),
            .o_full (w_stg_full[q])
        );
    end

    t_pkt w_cs_din;

    for (genvar c = 0; c < 2; c++) begin : g_cenq
        frt_fifo #(.DEPTH(CENTRAL_DEPTH)) u_cur (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_push (w_cc_push[c]),
            .i_din  (w_cs_head[c]),
            .i_pop  (w_cc_pop[c]),
            .o_head (w_cc_head[c]),
            .o_empty(w_cc_empty[c]),
            .o_full (w_cc_full[c])
        );
        frt_fifo #(.DEPTH(CENTRAL_DEPTH)) u_stg (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_push (w_cs_push[c]),
            .i_din  (w_cs_din),
            .i_pop  (w_cs_pop[c]),
            .o_head (w_cs_head[c]),
            .o_empty(w_cs_empty[c]),
            .o_full (w_cs_full[c])
        );
    end

    // drain: one packet per queue per cycle
    assign w_cur_push = i_ctl.drain ? (~w_stg_empty & ~w_cur_full) : '0;
    assign w_stg_pop  = w_cur_push;
    assign w_cc_push  = i_ctl.drain ? (~w_cs_empty & ~w_cc_full) : '0;
    assign w_cs_pop   = w_cc_push;

    // ---------------- command execution ----------------
    logic          w_lo_cmd, w_up_cmd, w_acc;
    logic [QW-1:0] w_q_in;
    logic          w_stg_ok;
    logic [1:0]    w_exec_cs_push;

    assign w_lo_cmd = (r_in_cmd == CMD_INJECT) || (r_in_cmd == CMD_RECV_LOWER);
    assign w_up_cmd = (r_in_cmd == CMD_RECV_UPPER);
    assign w_q_in   = w_lo_cmd ? QW'(r_in_port) : QW'(LOWER_PORTS) + QW'(r_in_port);
    assign w_stg_ok = !w_stg_full[w_q_in];

    always_comb begin
        w_stg_push     = '0;
        w_exec_cs_push = '0;
        w_acc          = 1'b0;
        if (w_lo_cmd || w_up_cmd) begin
            if (w_stg_ok) begin
                w_stg_push[w_q_in] = i_ctl.exec;
                w_acc              = 1'b1;
            end else if (w_lo_cmd && !w_cs_full[CEN_DOWN]) begin
                w_exec_cs_push[CEN_DOWN] = i_ctl.exec;
                w_acc                    = 1'b1;
            end else if (w_up_cmd && !w_cs_full[CEN_UP]) begin
                w_exec_cs_push[CEN_UP] = i_ctl.exec;
                w_acc                  = 1'b1;
            end
        end else if (r_in_cmd == CMD_CRED_UPPER || r_in_cmd == CMD_CRED_LOWER) begin
            w_acc = 1'b1;
        end
    end

    // ---------------- serve step ----------------
    logic          w_st_li, w_st_cu, w_st_ui, w_st_cd, w_is_port;
    logic [QW-1:0] w_q_sel;
    logic          w_c_sel;
    t_pkt          w_head;
    logic          w_hvalid;
    logic [7:0]    w_d;
    logic          w_is_local, w_below;

    assign w_st_li   = (i_ctl.step < STEP_W'(STEP_CUP));
    assign w_st_cu   = (i_ctl.step == STEP_W'(STEP_CUP));
    assign w_st_cd   = (i_ctl.step == STEP_W'(STEP_CDOWN));
    assign w_st_ui   = !w_st_li && !w_st_cu && !w_st_cd;
    assign w_is_port = w_st_li || w_st_ui;
    assign w_q_sel   = w_st_li ? QW'(i_ctl.step) : QW'(i_ctl.step - STEP_W'(1));
    assign w_c_sel   = w_st_cd;
    assign w_head    = w_is_port ? w_cur_head[w_q_sel] : w_cc_head[w_c_sel];
    assign w_hvalid  = w_is_port ? !w_cur_empty[w_q_sel] : !w_cc_empty[w_c_sel];
    assign w_d       = w_head[15:8];
    assign w_is_local = (w_d == r_rid);

    // downward: first matching lower port with credit from the rotating start
    logic          w_found_l;
    logic [PW-1:0] w_port_l;

    always_comb begin
        logic [PW-1:0] p;
        logic [7:0]    nb;
        w_found_l = 1'b0;
        w_port_l  = '0;
        w_below   = w_is_local;
        for (int i = 0; i < LOWER_PORTS; i++) begin
            p  = r_dn_rr + PW'(i);
            nb = r_lmap[{p, 3'b000} +: 8];
            if (nb != NO_NEIGHBOR && nb == w_d) begin
                w_below = 1'b1;
                if (!w_found_l && r_lcred[p] != '0) begin
                    w_found_l = 1'b1;
                    w_port_l  = p;
                end
            end
        end
    end

    // upward: connected port with most credits, first best wins
    logic          w_found_u;
    logic [PW-1:0] w_port_u;

    always_comb begin
        logic [PW-1:0] p;
        logic [CW-1:0] best_c;
        best_c    = '0;
        w_found_u = 1'b0;
        w_port_u  = '0;
        for (int i = 0; i < UPPER_PORTS; i++) begin
            p = r_up_rr + PW'(i);
            if (r_umap[{p, 3'b000} +: 8] != NO_NEIGHBOR &&
                (!w_found_u || r_ucred[p] > best_c)) begin
                w_found_u = 1'b1;
                best_c    = r_ucred[p];
                w_port_u  = p;
            end
        end
    end

    logic       w_pop, w_fwd, w_use_dn, w_use_up_rr, w_use_up_cred;
    logic [1:0] w_srv_cs_push;
    t_row       w_new_row;

    always_comb begin
        w_pop         = 1'b0;
        w_fwd         = 1'b0;
        w_use_dn      = 1'b0;
        w_use_up_rr   = 1'b0;
        w_use_up_cred = 1'b0;
        w_srv_cs_push = '0;
        w_new_row     = '0;
        w_new_row.fv  = 1'b1;
        w_new_row.pkt = w_head;
        if (i_ctl.serve && w_hvalid) begin
            if (w_is_local) begin
                w_pop             = 1'b1;
                w_fwd             = 1'b1;
                w_new_row.kind    = KIND_LOCAL;
                w_new_row.trouter = NO_NEIGHBOR;
            end else if (w_st_ui || w_st_cd || w_below) begin
                if (w_found_l) begin
                    w_pop             = 1'b1;
                    w_fwd             = 1'b1;
                    w_use_dn          = 1'b1;
                    w_new_row.kind    = KIND_DOWN;
                    w_new_row.tport   = w_port_l;
                    w_new_row.trouter = r_lmap[{w_port_l, 3'b000} +: 8];
                end else if (w_is_port && !w_cs_full[CEN_DOWN]) begin
                    w_pop                   = 1'b1;
                    w_srv_cs_push[CEN_DOWN] = 1'b1;
                end
            end else begin
                // round-robin moves past the chosen port even when it is blocked
                w_use_up_rr = w_found_u;
                if (w_found_u && r_ucred[w_port_u] != '0) begin
                    w_pop             = 1'b1;
                    w_fwd             = 1'b1;
                    w_use_up_cred     = 1'b1;
                    w_new_row.kind    = KIND_UP;
                    w_new_row.tport   = w_port_u;
                    w_new_row.trouter = r_umap[{w_port_u, 3'b000} +: 8];
                end else if (w_st_li && !w_cs_full[CEN_UP]) begin
                    w_pop                 = 1'b1;
                    w_srv_cs_push[CEN_UP] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        w_cur_pop = '0;
        w_cc_pop  = '0;
        if (w_pop) begin
            if (w_is_port) w_cur_pop[w_q_sel] = 1'b1;
            else           w_cc_pop[w_c_sel]  = 1'b1;
        end
    end

    assign w_cs_push = w_exec_cs_push | w_srv_cs_push;
    assign w_cs_din  = i_ctl.serve ? w_head : r_in_pkt;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rid  <= '0;
            r_umap <= '1;
            r_lmap <= '1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_ROUTER_ID: r_rid  <= i_cfg_wdata[7:0];
                REG_UPPER_MAP: r_umap <= i_cfg_wdata;
                REG_LOWER_MAP: r_lmap <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_in_cmd  <= i_cmd;
            r_in_port <= i_port;
            r_in_pkt  <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < UPPER_PORTS; i++) r_ucred[i] <= CW'(MAX_CREDITS);
            for (int i = 0; i < LOWER_PORTS; i++) r_lcred[i] <= CW'(MAX_CREDITS);
            r_up_rr <= '0;
            r_dn_rr <= '0;
        end else begin
            if (i_ctl.exec && r_in_cmd == CMD_CRED_UPPER &&
                r_ucred[r_in_port] != CW'(MAX_CREDITS)) begin
                r_ucred[r_in_port] <= r_ucred[r_in_port] + CW'(1);
            end
            if (i_ctl.exec && r_in_cmd == CMD_CRED_LOWER &&
                r_lcred[r_in_port] != CW'(MAX_CREDITS)) begin
                r_lcred[r_in_port] <= r_lcred[r_in_port] + CW'(1);
            end
            if (w_use_dn) begin
                r_lcred[w_port_l] <= r_lcred[w_port_l] - CW'(1);
                r_dn_rr           <= w_port_l + PW'(1);
            end
            if (w_use_up_cred) r_ucred[w_port_u] <= r_ucred[w_port_u] - CW'(1);
            if (w_use_up_rr)   r_up_rr <= w_port_u + PW'(1);
        end
    end

    // hold the newest forward back until the next one shows it was not last
    assign w_out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_ctl.exec || i_ctl.flush || (w_fwd && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fwd)            r_pend_valid <= 1'b1;
            else if (i_ctl.flush) r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_out      <= '0;
            r_out.acc  <= w_acc;
            r_out_last <= 1'b1;
        end else if (i_ctl.flush) begin
            r_out      <= r_pend_valid ? r_pend : '0;
            r_out_last <= 1'b1;
        end else if (w_fwd && r_pend_valid) begin
            r_out      <= r_pend;
            r_out_last <= 1'b0;
        end
        if (w_fwd) r_pend <= w_new_row;
    end

    assign o_valid = r_out_valid;
    assign o_row   = r_out;
    assign o_last  = r_out_last;

    assign o_stat.in_is_tick = (i_cmd == CMD_TICK);
    assign o_stat.out_free   = w_out_free;
    assign o_stat.drain_busy = (|(~w_stg_empty & ~w_cur_full)) ||
                               (|(~w_cs_empty & ~w_cc_full));
    assign o_stat.pend_valid = r_pend_valid;

endmodule
